// ----- rtl/core/imat_pkg.sv -----
// ----------------------------------------------------------------------------
// imat_pkg
// Shared types, codes and instruction encoders for the immediate materializer.
// ----------------------------------------------------------------------------
package imat_pkg;

    // Stream and register widths
    localparam int REG_W      = 5;
    localparam int VALUE_W    = 64;
    localparam int WORD_W     = 32;
    localparam int S_DATA_W   = 72;   // dest_reg + value, padded to whole bytes
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int FIFO_DEPTH = 2;

    localparam logic [REG_W-1:0] SCRATCH_RESET = 5'd7;

    // Register index of scratch_reg
    localparam logic REG_IDX_SCRATCH = 1'b0;

    // Sequence kinds
    localparam logic [1:0] KIND_ONE  = 2'd0;  // addi rd,x0,imm
    localparam logic [1:0] KIND_PAIR = 2'd1;  // lui + addiw
    localparam logic [1:0] KIND_FULL = 2'd2;  // eight-word sequence

    // Opcodes and funct3 codes
    localparam logic [6:0] OPC_OP_IMM    = 7'h13;
    localparam logic [6:0] OPC_OP_IMM_32 = 7'h1B;
    localparam logic [6:0] OPC_OP        = 7'h33;
    localparam logic [6:0] OPC_LUI       = 7'h37;
    localparam logic [2:0] F3_ADD        = 3'd0;
    localparam logic [2:0] F3_SLL        = 3'd1;
    localparam logic [2:0] F3_SRL        = 3'd5;
    localparam logic [11:0] SHAMT_32     = 12'd32;

    // One classified item waiting for the sequencer
    typedef struct packed {
        logic [1:0]       kind;
        logic [REG_W-1:0] dest;
        logic [19:0]      hi_h;   // upper split of value[63:32]
        logic [11:0]      lo_h;
        logic [19:0]      hi_l;   // upper split of value[31:0]
        logic [11:0]      lo_l;
    } t_entry;

    function automatic logic [WORD_W-1:0] enc_i(
        input logic [11:0]      imm,
        input logic [REG_W-1:0] rs1,
        input logic [2:0]       f3,
        input logic [REG_W-1:0] rd,
        input logic [6:0]       opc
    );
        enc_i = {imm, rs1, f3, rd, opc};
    endfunction

    function automatic logic [WORD_W-1:0] enc_u(
        input logic [19:0]      imm,
        input logic [REG_W-1:0] rd
    );
        enc_u = {imm, rd, OPC_LUI};
    endfunction

    function automatic logic [WORD_W-1:0] enc_add(
        input logic [REG_W-1:0] rd,
        input logic [REG_W-1:0] rs1,
        input logic [REG_W-1:0] rs2
    );
        enc_add = {7'd0, rs2, rs1, F3_ADD, rd, OPC_OP};
    endfunction

endpackage

// ----- rtl/core/imat_front.sv -----
// ----------------------------------------------------------------------------
// imat_front
// Accepts items, classifies the value range and splits both 32-bit halves.
// ----------------------------------------------------------------------------
module imat_front (
    input  logic                            i_valid,
    input  logic [imat_pkg::S_DATA_W-1:0]   i_data,
    input  logic                            i_full,
    output logic                            o_ready,
    output logic                            o_push,
    output imat_pkg::t_entry                o_entry
);
    import imat_pkg::*;

    logic [REG_W-1:0]   dest;
    logic [VALUE_W-1:0] value;
    logic [31:0]        sum_h;
    logic [31:0]        sum_l;
    logic               fits12;
    logic               fits32;

    assign dest  = i_data[REG_W-1:0];
    assign value = i_data[REG_W +: VALUE_W];

    // Signed range checks: the upper bits are all copies of the sign
    assign fits12 = (&value[63:11]) | ~(|value[63:11]);
    assign fits32 = (&value[63:31]) | ~(|value[63:31]);

    // Round each half so that lui plus a signed 12-bit add rebuilds it
    assign sum_h = value[63:32] + 32'h0000_0800;
    assign sum_l = value[31:0]  + 32'h0000_0800;

    always_comb begin
        o_entry.dest = dest;
        o_entry.hi_h = sum_h[31:12];
        o_entry.lo_h = value[43:32];
        o_entry.hi_l = sum_l[31:12];
        o_entry.lo_l = value[11:0];
        priority if (fits12) begin
            o_entry.kind = KIND_ONE;
        end else if (fits32) begin
            o_entry.kind = KIND_PAIR;
        end else begin
            o_entry.kind = KIND_FULL;
        end
    end

    assign o_ready = ~i_full;
    assign o_push  = i_valid & ~i_full;

endmodule

// ----- rtl/core/imat_fifo.sv -----
// ----------------------------------------------------------------------------
// imat_fifo
// Short queue of classified items between the front and the sequencer.
// ----------------------------------------------------------------------------
module imat_fifo #(
    parameter int DEPTH = imat_pkg::FIFO_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  imat_pkg::t_entry  i_entry,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_valid,
    output imat_pkg::t_entry  o_entry
);
    import imat_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_entry           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & o_valid;

    // Advance pointers with wrap at the depth
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store payload
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

// ----- rtl/core/imat_back.sv -----
// ----------------------------------------------------------------------------
// imat_back
// Steps through the head item's instruction words, one per cycle while not stalled.
// ----------------------------------------------------------------------------
module imat_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  imat_pkg::t_entry                 i_entry,
    input  logic [imat_pkg::REG_W-1:0]       i_scratch,
    output logic                             o_pop,
    output logic                             o_valid,
    output logic [imat_pkg::WORD_W-1:0]      o_word,
    output logic                             o_last,
    input  logic                             i_ready
);
    import imat_pkg::*;

    logic [2:0]        r_idx, n_idx;
    logic              r_valid;
    logic [WORD_W-1:0] r_word;
    logic              r_last;
    logic [WORD_W-1:0] word;
    logic              last;
    logic              load;
    logic [REG_W-1:0]  rd;
    logic [REG_W-1:0]  sr;

    assign rd = i_entry.dest;
    assign sr = i_scratch;

    // Build the word at the current step of the sequence
    always_comb begin
        word = '0;
        last = 1'b0;
        unique case (i_entry.kind)
            KIND_ONE: begin
                word = enc_i(i_entry.lo_l, '0, F3_ADD, rd, OPC_OP_IMM);
                last = 1'b1;
            end
            KIND_PAIR: begin
                last = r_idx[0];
                word = r_idx[0] ? enc_i(i_entry.lo_l, rd, F3_ADD, rd, OPC_OP_IMM_32)
                                : enc_u(i_entry.hi_l, rd);
            end
            KIND_FULL: begin
                last = (r_idx == 3'd7);
                unique case (r_idx)
                    3'd0: word = enc_u(i_entry.hi_h, rd);
                    3'd1: word = enc_i(i_entry.lo_h, rd, F3_ADD, rd, OPC_OP_IMM_32);
                    3'd2: word = enc_i(SHAMT_32, rd, F3_SLL, rd, OPC_OP_IMM);
                    3'd3: word = enc_u(i_entry.hi_l, sr);
                    3'd4: word = enc_i(i_entry.lo_l, sr, F3_ADD, sr, OPC_OP_IMM_32);
                    3'd5: word = enc_i(SHAMT_32, sr, F3_SLL, sr, OPC_OP_IMM);
                    3'd6: word = enc_i(SHAMT_32, sr, F3_SRL, sr, OPC_OP_IMM);
                    3'd7: word = enc_add(rd, rd, sr);
                    default: word = '0;
                endcase
            end
            default: begin
                word = '0;
                last = 1'b1;
            end
        endcase
    end

    // Load the output register when an item waits and the register is empty or being taken
    assign load  = i_valid & (~r_valid | i_ready);
    assign o_pop = load & last;

    always_comb begin
        n_idx = r_idx;
        if (load) begin
            n_idx = last ? 3'd0 : r_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_idx <= n_idx;
            if (load) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Hold payload until taken
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_word <= word;
            r_last <= last;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;
    assign o_last  = r_last;

endmodule

// ----- rtl/core/riscv_immediate_materializer.sv -----
// ----------------------------------------------------------------------------
// riscv_immediate_materializer
// Expands (dest_reg, 64-bit value) into the RV64 words that load the value.
// ----------------------------------------------------------------------------
// Each input item yields one word (addi) for a signed 12-bit value, two words
// (lui, addiw) for a signed 32-bit value and eight words otherwise, the last
// of which is marked by m_axis_tlast. The output runs at one word per clock
// while items are queued and m_axis_tready is high, paced by the single-word
// output register of the sequencer. A two-entry queue sits between the
// classifying front and the sequencer, so new items are taken while earlier
// words are still going out. The eight-word form clobbers the register in
// scratch_reg (APB address 0, reset 7); configure it only while the block is
// idle.
module riscv_immediate_materializer #(
    parameter int FIFO_DEPTH = imat_pkg::FIFO_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input stream: tdata = {pad[2:0], value[63:0], dest_reg[4:0]}
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [imat_pkg::S_DATA_W-1:0]     s_axis_tdata,
    // Output stream: tdata = instr_word[31:0]; tlast = last_word
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [imat_pkg::WORD_W-1:0]       m_axis_tdata,
    output logic                              m_axis_tlast,
    // Configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [imat_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [imat_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [imat_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import imat_pkg::*;

    logic [REG_W-1:0] r_scratch_reg;
    logic             reg_idx;
    logic             push;
    logic             full;
    logic             q_valid;
    logic             pop;
    t_entry           f_entry;
    t_entry           q_entry;

    // Register file: scratch_reg sits at word address 0; word address 4 reads as zero
    assign reg_idx = paddr[2];
    assign pready  = 1'b1;
    assign prdata  = (reg_idx == REG_IDX_SCRATCH) ?
                     {{(APB_DATA_W-REG_W){1'b0}}, r_scratch_reg} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scratch_reg <= SCRATCH_RESET;
        end else if (psel && penable && pwrite && (reg_idx == REG_IDX_SCRATCH)) begin
            r_scratch_reg <= pwdata[REG_W-1:0];
        end
    end

    imat_front u_front (
        .i_valid (s_axis_tvalid),
        .i_data  (s_axis_tdata),
        .i_full  (full),
        .o_ready (s_axis_tready),
        .o_push  (push),
        .o_entry (f_entry)
    );

    imat_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (f_entry),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (q_valid),
        .o_entry (q_entry)
    );

    imat_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (q_valid),
        .i_entry   (q_entry),
        .i_scratch (r_scratch_reg),
        .o_pop     (pop),
        .o_valid   (m_axis_tvalid),
        .o_word    (m_axis_tdata),
        .o_last    (m_axis_tlast),
        .i_ready   (m_axis_tready)
    );

endmodule

// ----- rtl/core/imat_checker.sv -----
// ----------------------------------------------------------------------------
// imat_checker
// Port-level checks on the immediate materializer, bound to the top level.
// ----------------------------------------------------------------------------
module imat_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [imat_pkg::WORD_W-1:0]       m_axis_tdata,
    input logic                              m_axis_tlast,
    input logic                              pready
);
    import imat_pkg::*;

    // Output holds while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output changed while stalled");

    // Reset empties the output stage
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    // A sequence ends in addi, addiw or add
    a_last_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |->
            (m_axis_tdata[6:0] == OPC_OP_IMM) || (m_axis_tdata[6:0] == OPC_OP_IMM_32) ||
            (m_axis_tdata[6:0] == OPC_OP))
        else $error("last word has an unexpected opcode");

    // The merging add only closes a sequence
    a_add_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[6:0] == OPC_OP) |-> m_axis_tlast)
        else $error("add word not marked last");

    a_pready: assert property (@(posedge i_clk) pready)
        else $error("pready low");

endmodule

bind riscv_immediate_materializer imat_checker u_imat_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .pready        (pready)
);
